[hw/rtl/bchd_pkg.sv]
package bchd_pkg;

   // Click state machine states
   typedef enum logic [1:0] {
      ST_IDLE     = 2'd0,
      ST_PRESSED  = 2'd1,
      ST_WAIT     = 2'd2,
      ST_PRESSED2 = 2'd3
   } click_state_type;

   // Event codes carried on the result channel
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PRESS   = 3'd1,
      EV_RELEASE = 3'd2,
      EV_CLICK   = 3'd3,
      EV_DOUBLE  = 3'd4,
      EV_HOLD    = 3'd5
   } event_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_DEBOUNCE_TIME = 2'd0,
      CSR_HOLD_TIME     = 2'd1,
      CSR_DC_WINDOW     = 2'd2,
      CSR_ACTIVE_LOW    = 2'd3
   } csr_index_type;

   localparam int unsigned TIMER_W = 16;
   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

endpackage

[hw/rtl/button_click_hold_detector.sv]
// Debounce and click/double-click/hold detection for one push button.
//
// Input channel (req_): one raw pin sample per beat, one beat per scan tick.
// Result channel (rsp_): one or two beats per tick carrying the event code,
// last_of_tick on the final beat of the tick, and the debounced level.
// Configuration channel (csr_): register index and write data, always ready;
// write only while no tick is in flight.
//
// A sample accepted is held in the input register, is evaluated once the
// result register is free, and its first result beat is offered from then on.
// Throughput: one tick per cycle while rsp_ready is high and each tick yields
// one result; a tick that yields two (release plus click or double click)
// holds the next back until its second beat leaves the two-beat result register.
// Reset clears the timers, the debounce and click state and loads the
// configuration defaults. When the receiver stalls, one result pair waits in
// the result register and one more sample waits in the input register; then
// req_ready drops.
module button_click_hold_detector
   import bchd_pkg::*;
#(
   parameter int unsigned SCAN_PERIOD_MS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_pin_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_code,
   output logic        rsp_last_of_tick,
   output logic        rsp_pressed_now,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [TIMER_W:0] STEP = (TIMER_W+1)'(SCAN_PERIOD_MS);

   function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] t);
      logic [TIMER_W:0] s;
      s = {1'b0, t} + STEP;
      return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
   endfunction

   // Configuration registers
   logic [TIMER_W-1:0] debounce_time_ff, hold_time_ff, dc_window_ff;
   logic               active_low_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff <= 16'd50;
         hold_time_ff     <= 16'd1000;
         dc_window_ff     <= 16'd300;
         active_low_ff    <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_TIME: debounce_time_ff <= csr_data;
            CSR_HOLD_TIME:     hold_time_ff     <= csr_data;
            CSR_DC_WINDOW:     dc_window_ff     <= csr_data;
            CSR_ACTIVE_LOW:    active_low_ff    <= csr_data[0];
            default:           ;
         endcase
      end
   end

   // Input register and result register control
   logic       in_valid_ff, in_level_ff;
   logic [1:0] out_cnt_ff, out_cnt_in;
   logic       out_free, advance, rsp_fire;

   assign rsp_fire  = rsp_valid && rsp_ready;
   assign out_free  = (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_ready);
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_level_ff <= req_pin_level;
      end
   end

   // Debounce
   logic               raw_prev_ff, debounced_ff;
   logic [TIMER_W-1:0] stable_ff, stable_in;
   logic               raw, cur, jp, jr;

   assign raw       = active_low_ff ? ~in_level_ff : in_level_ff;
   assign stable_in = (raw != raw_prev_ff) ? '0 : sat_add(stable_ff);
   assign cur       = (stable_in >= debounce_time_ff) ? raw : debounced_ff;
   assign jp        = cur && !debounced_ff;
   assign jr        = !cur && debounced_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff  <= 1'b0;
         stable_ff    <= '0;
         debounced_ff <= 1'b0;
      end else if (advance) begin
         raw_prev_ff  <= raw;
         stable_ff    <= stable_in;
         debounced_ff <= cur;
      end
   end

   // Click state machine registers
   click_state_type    state_ff, state_in;
   logic [TIMER_W-1:0] held_ff, held_in, wait_ff, wait_in;
   logic [TIMER_W-1:0] held_inc, wait_inc;
   logic               hold_sent_ff, hold_sent_in;
   logic               hold_fire;

   assign held_inc  = sat_add(held_ff);
   assign wait_inc  = sat_add(wait_ff);
   assign hold_fire = cur && !hold_sent_ff && (hold_time_ff != '0) &&
                      (held_inc >= hold_time_ff);

   // Next state and timers
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      wait_in      = wait_ff;
      hold_sent_in = hold_sent_ff;
      case (state_ff)
         ST_IDLE: begin
            if (jp) begin
               state_in     = ST_PRESSED;
               held_in      = '0;
               hold_sent_in = 1'b0;
            end
         end
         ST_PRESSED: begin
            if (cur && !hold_sent_ff) begin
               held_in = held_inc;
            end
            if (hold_fire) begin
               hold_sent_in = 1'b1;
            end
            if (jr) begin
               if (hold_sent_ff || (dc_window_ff == '0)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_WAIT;
                  wait_in  = '0;
               end
            end
         end
         ST_WAIT: begin
            wait_in = wait_inc;
            if (jp) begin
               state_in = ST_PRESSED2;
            end else if (wait_inc >= dc_window_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_PRESSED2: begin
            if (jr) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Events for this tick
   event_type ev_a, ev_b;
   logic      ev_two;

   always_comb begin
      ev_a   = EV_NONE;
      ev_b   = EV_NONE;
      ev_two = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (jp) ev_a = EV_PRESS;
         end
         ST_PRESSED: begin
            // hold needs the level up, release needs it down: never both
            if (hold_fire) begin
               ev_a = EV_HOLD;
            end else if (jr) begin
               ev_a = EV_RELEASE;
               if (!hold_sent_ff && (dc_window_ff == '0)) begin
                  ev_b   = EV_CLICK;
                  ev_two = 1'b1;
               end
            end
         end
         ST_WAIT: begin
            if (jp) begin
               ev_a = EV_PRESS;
            end else if (wait_inc >= dc_window_ff) begin
               ev_a = EV_CLICK;
            end
         end
         ST_PRESSED2: begin
            if (jr) begin
               ev_a   = EV_RELEASE;
               ev_b   = EV_DOUBLE;
               ev_two = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         wait_ff      <= '0;
         hold_sent_ff <= 1'b0;
      end else if (advance) begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         wait_ff      <= wait_in;
         hold_sent_ff <= hold_sent_in;
      end
   end

   // Result register: up to two beats, second shifts forward
   event_type ev0_ff, ev1_ff;
   logic      pressed_ff;

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (advance) begin
         out_cnt_in = ev_two ? 2'd2 : 2'd1;
      end else if (rsp_fire) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ev0_ff     <= ev_a;
         ev1_ff     <= ev_b;
         pressed_ff <= cur;
      end else if (rsp_fire) begin
         ev0_ff <= ev1_ff;
      end
   end

   assign rsp_valid        = (out_cnt_ff != 2'd0);
   assign rsp_event_code   = ev0_ff;
   assign rsp_last_of_tick = (out_cnt_ff == 2'd1);
   assign rsp_pressed_now  = pressed_ff;

   // Checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("result count out of range");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("evaluated tick produced no result beat");

   a_pair_shift: assert property (@(posedge clock) disable iff (reset)
      (out_cnt_ff == 2'd2 && rsp_ready) |=> (out_cnt_ff == 2'd1 && rsp_valid))
      else $error("second beat of a tick lost");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      hold_sent_ff |-> (state_ff == ST_IDLE || state_ff == ST_PRESSED))
      else $error("hold flag set outside first press");

endmodule
